>>> design/oal_pkg.sv
// Shared types, codes and sizes for the ordered array list.
package oal_pkg;

    localparam int CAPACITY_DEF = 64;
    localparam int POS_W        = 7;
    localparam int VAL_W        = 32;
    localparam int GROUP        = 8;

    typedef enum logic [2:0] {
        ACT_PUSH_FRONT = 3'd0,
        ACT_PUSH_BACK  = 3'd1,
        ACT_INSERT_AT  = 3'd2,
        ACT_POP_FRONT  = 3'd3,
        ACT_POP_BACK   = 3'd4,
        ACT_REMOVE_AT  = 3'd5,
        ACT_READ_AT    = 3'd6
    } action_t;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_FULL   = 2'd1,
        ST_EMPTY  = 2'd2,
        ST_BADIDX = 2'd3
    } status_t;

    typedef struct packed {
        logic             ins;
        logic             rem;
        logic [VAL_W-1:0] value;
    } cell_ctl_t;

endpackage

>>> design/oal_if.sv
// Valid/ready channel interfaces for list requests and responses.
interface oal_req_if;
    logic                            valid;
    logic                            ready;
    logic [2:0]                      action;
    logic [oal_pkg::POS_W-1:0]       position;
    logic signed [oal_pkg::VAL_W-1:0] value;

    modport source (output valid, output action, output position, output value, input ready);
    modport sink (input valid, input action, input position, input value, output ready);
endinterface

interface oal_rsp_if;
    logic                             valid;
    logic                             ready;
    logic [1:0]                       status;
    logic [oal_pkg::POS_W-1:0]        count;
    logic signed [oal_pkg::VAL_W-1:0] read_value;

    modport source (output valid, output status, output count, output read_value, input ready);
    modport sink (input valid, input status, input count, input read_value, output ready);
endinterface

>>> design/oal_cell.sv
// One storage cell of the list; shifts toward either neighbor on insert or remove.
module oal_cell #(
    parameter int INDEX = 0,
    parameter int PW    = oal_pkg::POS_W
) (
    input  logic                       clk,
    input  oal_pkg::cell_ctl_t         ctl,
    input  logic [PW-1:0]              pos,
    input  logic [oal_pkg::VAL_W-1:0]  left_elem,
    input  logic [oal_pkg::VAL_W-1:0]  right_elem,
    output logic [oal_pkg::VAL_W-1:0]  elem
);

    localparam logic [PW-1:0] MY_IDX = PW'(INDEX);

    logic [oal_pkg::VAL_W-1:0] elem_reg;
    logic [oal_pkg::VAL_W-1:0] elem_next;

    always_comb
    begin
        elem_next = elem_reg;
        if (ctl.ins)
        begin
            if (MY_IDX > pos)
                elem_next = left_elem;
            else if (MY_IDX == pos)
                elem_next = ctl.value;
        end
        else if (ctl.rem)
        begin
            if (MY_IDX >= pos)
                elem_next = right_elem;
        end
    end

    always_ff @(posedge clk)
    begin
        elem_reg <= elem_next;
    end

    assign elem = elem_reg;

endmodule

>>> design/oal_gather.sv
// Registered two-level selection of the cell named by a read position.
module oal_gather #(
    parameter int CAPACITY = oal_pkg::CAPACITY_DEF,
    parameter int PW       = oal_pkg::POS_W
) (
    input  logic                      clk,
    input  logic                      load,
    input  logic [PW-1:0]             pos,
    input  logic [oal_pkg::VAL_W-1:0] elems [CAPACITY],
    output logic [oal_pkg::VAL_W-1:0] sel
);

    localparam int NGROUP = (CAPACITY + oal_pkg::GROUP - 1) / oal_pkg::GROUP;
    localparam int NPAD   = NGROUP * oal_pkg::GROUP;

    logic [oal_pkg::VAL_W-1:0] masked   [NPAD];
    logic [oal_pkg::VAL_W-1:0] grp_next [NGROUP];
    logic [oal_pkg::VAL_W-1:0] grp_reg  [NGROUP];

    for (genvar i = 0; i < NPAD; i++)
    begin : g_mask
        if (i < CAPACITY)
        begin : g_real
            assign masked[i] = (PW'(i) == pos) ? elems[i] : '0;
        end
        else
        begin : g_pad
            assign masked[i] = '0;
        end
    end

    always_comb
    begin
        for (int g = 0; g < NGROUP; g++)
        begin
            grp_next[g] = '0;
            for (int k = 0; k < oal_pkg::GROUP; k++)
                grp_next[g] = grp_next[g] | masked[g * oal_pkg::GROUP + k];
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            for (int g = 0; g < NGROUP; g++)
                grp_reg[g] <= grp_next[g];
        end
    end

    always_comb
    begin
        sel = '0;
        for (int g = 0; g < NGROUP; g++)
            sel = sel | grp_reg[g];
    end

endmodule

>>> design/ordered_array_list.sv
// Top level of the ordered array list: control, cell chain and read selection.
//
//   channel  direction  fields
//   req      sink       action, position, value
//   rsp      source     status, count, read_value
//
// The cell chain updates at the accepting edge. The read selection then registers each tree
// level in turn, first the groups in the group registers and then the result in the result
// register, which offers it; the next item can be accepted at the same edge that takes it.
// Reset empties the list at once; cell contents are not cleared.
// A stalled result holds until taken and blocks further items.
module ordered_array_list #(
    parameter int CAPACITY = oal_pkg::CAPACITY_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    oal_req_if.sink      req,
    oal_rsp_if.source    rsp
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int PW    = (CNT_W > oal_pkg::POS_W) ? CNT_W : oal_pkg::POS_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_GATHER,
        S_FINISH,
        S_OUT
    } state_t;

    state_t                    state_reg;
    logic [CNT_W-1:0]          used_reg;
    logic [1:0]                status_reg;
    logic [oal_pkg::POS_W-1:0] count_reg;
    logic [oal_pkg::VAL_W-1:0] rdata_reg;
    logic [PW-1:0]             rpos_reg;
    logic                      rd_ok_reg;

    logic                      accept;
    logic                      full;
    logic                      empty;
    logic [PW-1:0]             posx;
    logic [PW-1:0]             usedx;
    logic [PW-1:0]             gap_pos;
    logic                      do_ins;
    logic                      do_rem;
    logic                      do_drop;
    logic                      do_read;
    oal_pkg::status_t          status_next;
    logic [CNT_W-1:0]          used_next;
    oal_pkg::cell_ctl_t        ctl;
    logic [oal_pkg::VAL_W-1:0] elem [CAPACITY];
    logic [oal_pkg::VAL_W-1:0] sel;

    assign req.ready = (state_reg == S_IDLE) || ((state_reg == S_OUT) && rsp.ready);
    assign accept    = req.valid && req.ready;

    assign full  = (used_reg >= CNT_W'(CAPACITY));
    assign empty = (used_reg == '0);
    assign posx  = PW'(req.position);
    assign usedx = PW'(used_reg);

    always_comb
    begin
        status_next = oal_pkg::ST_OK;
        gap_pos     = '0;
        do_ins      = 1'b0;
        do_rem      = 1'b0;
        do_drop     = 1'b0;
        do_read     = 1'b0;
        unique case (req.action)
            oal_pkg::ACT_PUSH_FRONT:
            begin
                if (full) status_next = oal_pkg::ST_FULL;
                else do_ins = 1'b1;
            end
            oal_pkg::ACT_PUSH_BACK:
            begin
                gap_pos = usedx;
                if (full) status_next = oal_pkg::ST_FULL;
                else do_ins = 1'b1;
            end
            oal_pkg::ACT_INSERT_AT:
            begin
                gap_pos = posx;
                if (full) status_next = oal_pkg::ST_FULL;
                else if (posx > usedx) status_next = oal_pkg::ST_BADIDX;
                else do_ins = 1'b1;
            end
            oal_pkg::ACT_POP_FRONT:
            begin
                if (empty) status_next = oal_pkg::ST_EMPTY;
                else do_rem = 1'b1;
            end
            oal_pkg::ACT_POP_BACK:
            begin
                if (empty) status_next = oal_pkg::ST_EMPTY;
                else do_drop = 1'b1;
            end
            oal_pkg::ACT_REMOVE_AT:
            begin
                gap_pos = posx;
                if (empty) status_next = oal_pkg::ST_EMPTY;
                else if (posx >= usedx) status_next = oal_pkg::ST_BADIDX;
                else do_rem = 1'b1;
            end
            oal_pkg::ACT_READ_AT:
            begin
                if (empty) status_next = oal_pkg::ST_EMPTY;
                else if (posx >= usedx) status_next = oal_pkg::ST_BADIDX;
                else do_read = 1'b1;
            end
            default:
            begin
                status_next = oal_pkg::ST_BADIDX;
            end
        endcase
    end

    always_comb
    begin
        used_next = used_reg;
        if (do_ins)
            used_next = used_reg + CNT_W'(1);
        else if (do_rem || do_drop)
            used_next = used_reg - CNT_W'(1);
    end

    assign ctl.ins   = accept && do_ins;
    assign ctl.rem   = accept && do_rem;
    assign ctl.value = req.value;

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic [oal_pkg::VAL_W-1:0] left_elem;
        logic [oal_pkg::VAL_W-1:0] right_elem;

        if (i == 0)
        begin : g_first
            assign left_elem = '0;
        end
        else
        begin : g_left
            assign left_elem = elem[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_last
            assign right_elem = '0;
        end
        else
        begin : g_right
            assign right_elem = elem[i+1];
        end

        oal_cell #(
            .INDEX (i),
            .PW    (PW)
        ) u_cell (
            .clk        (clk),
            .ctl        (ctl),
            .pos        (gap_pos),
            .left_elem  (left_elem),
            .right_elem (right_elem),
            .elem       (elem[i])
        );
    end

    oal_gather #(
        .CAPACITY (CAPACITY),
        .PW       (PW)
    ) u_gather (
        .clk   (clk),
        .load  (state_reg == S_GATHER),
        .pos   (rpos_reg),
        .elems (elem),
        .sel   (sel)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            used_reg   <= '0;
            status_reg <= oal_pkg::ST_OK;
            count_reg  <= '0;
            rdata_reg  <= '0;
            rpos_reg   <= '0;
            rd_ok_reg  <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE, S_OUT:
                begin
                    if (accept)
                    begin
                        state_reg  <= S_GATHER;
                        used_reg   <= used_next;
                        status_reg <= status_next;
                        count_reg  <= oal_pkg::POS_W'(used_next);
                        rpos_reg   <= posx;
                        rd_ok_reg  <= do_read;
                    end
                    else if (state_reg == S_OUT && rsp.ready)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_GATHER:
                begin
                    state_reg <= S_FINISH;
                end
                S_FINISH:
                begin
                    state_reg <= S_OUT;
                    rdata_reg <= rd_ok_reg ? sel : '0;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign rsp.valid      = (state_reg == S_OUT);
    assign rsp.status     = status_reg;
    assign rsp.count      = count_reg;
    assign rsp.read_value = rdata_reg;

endmodule

>>> design/oal_checker.sv
// Port-level assertions for the ordered array list and their binding.
module oal_port_props #(
    parameter int CAPACITY = oal_pkg::CAPACITY_DEF
) (
    input logic                      clk,
    input logic                      rst_n,
    input logic                      req_valid,
    input logic                      req_ready,
    input logic                      rsp_valid,
    input logic                      rsp_ready,
    input logic [1:0]                rsp_status,
    input logic [oal_pkg::POS_W-1:0] rsp_count,
    input logic [oal_pkg::VAL_W-1:0] rsp_read_value
);

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
            && $stable(rsp_count) && $stable(rsp_read_value))
        else $error("Stalled response item changed.");

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |-> ##3 rsp_valid)
        else $error("Response item did not appear three cycles after acceptance.");

    a_read_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_status != oal_pkg::ST_OK |-> rsp_read_value == '0)
        else $error("Failed action returned a nonzero read value.");

    a_full_empty: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp_status != oal_pkg::ST_FULL
                || rsp_count == oal_pkg::POS_W'(CAPACITY))
            && (rsp_status != oal_pkg::ST_EMPTY || rsp_count == '0))
        else $error("Full or empty status disagrees with the count.");

endmodule

bind ordered_array_list oal_port_props #(.CAPACITY(CAPACITY)) u_oal_port_props (
    .clk            (clk),
    .rst_n          (rst_n),
    .req_valid      (req.valid),
    .req_ready      (req.ready),
    .rsp_valid      (rsp.valid),
    .rsp_ready      (rsp.ready),
    .rsp_status     (rsp.status),
    .rsp_count      (rsp.count),
    .rsp_read_value (rsp.read_value)
);
